// ===== src/tcse_pkg.sv =====
// Shared types, codes and defaults for the text console scrollback engine.
// No dependencies.
`timescale 1ns / 1ps

package tcse_pkg;

  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;
  localparam int RING_LINES_DEF  = 256;
  localparam int TAB_STOP_DEF    = 4;

  localparam logic [7:0] RESET_COLOR = 8'h07;

  localparam logic [2:0] OP_CONSOLE = 3'd0;
  localparam logic [2:0] OP_WCHAR   = 3'd1;
  localparam logic [2:0] OP_WCOLOR  = 3'd2;
  localparam logic [2:0] OP_VUP     = 3'd3;
  localparam logic [2:0] OP_VDOWN   = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;
  localparam logic [2:0] OP_READ    = 3'd6;
  localparam logic [2:0] OP_NOP     = 3'd7;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] LINE_CURSOR = 2'd0;
  localparam logic [1:0] LINE_LIVE   = 2'd1;
  localparam logic [1:0] LINE_VIEW   = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
    logic [7:0] line_count;
  } in_t;

  typedef struct packed {
    logic [7:0]  shown_char;
    logic [7:0]  shown_color;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [10:0] cursor_pos;
    logic        cursor_shown;
    logic [7:0]  view_depth;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;
    logic       line_en;
    logic [1:0] line_sel;
    logic       addr_en;
    logic       wr_char;
    logic       wr_color;
    logic       rd;
    logic       step;
    logic       newline;
    logic       cret;
    logic       tab_load;
    logic       view_upd;
    logic       clear_regs;
    logic       sweep_line;
    logic       sweep_screen;
    logic       sweep_wr;
    logic       sweep_init;
    logic       load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       is_nl;
    logic       is_cr;
    logic       is_tab;
    logic       cell_ok;
    logic       scroll;
    logic       sweep_last;
    logic       tab_more;
  } stat_t;

endpackage

// ===== src/tcse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/tcse_datapath.sv =====
// Datapath: cursor, ring head, view, sweep counters, address forming and the cell stores.
// Depends on tcse_pkg and tcse_ram.
`timescale 1ns / 1ps

module tcse_datapath #(
  parameter int SCREEN_COLS = tcse_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcse_pkg::SCREEN_ROWS_DEF,
  parameter int RING_LINES  = tcse_pkg::RING_LINES_DEF,
  parameter int TAB_STOP    = tcse_pkg::TAB_STOP_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  input  tcse_pkg::in_t   in_data,
  input  tcse_pkg::cmd_t  cmd,
  output tcse_pkg::stat_t st,
  output tcse_pkg::out_t  out_data
);

  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int LW    = $clog2(RING_LINES);
  localparam int XW    = LW + 2;
  localparam int VW    = (LW > 8) ? LW + 1 : 9;
  localparam int PW    = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
  localparam int TW    = $clog2(TAB_STOP + 1);
  localparam int CELLS = RING_LINES * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int KEPT_MAX = RING_LINES - SCREEN_ROWS;

  tcse_pkg::in_t item;
  logic [7:0]    blank_color;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [PW-1:0] phase;
  logic [TW-1:0] tab_left;
  logic [LW-1:0] head, kept, view, line_q;
  logic          scroll_q;
  logic [AW-1:0] addr_q, sweep_addr, sweep_end;

  logic          cell_ok, is_console;
  logic [XW-1:0] line_live, line_cur, line_view_t, line_view;
  logic [XW-1:0] sum_live, sum_cur, sum_vt, sum_vu;
  logic [AW-1:0] prod, addr_next;
  logic [LW-1:0] head_inc, bottom_line;
  logic [XW-1:0] bottom_sum;
  logic [VW-1:0] vsum;
  logic          wr_c, wr_k;
  logic [AW-1:0] waddr;
  logic [7:0]    wchar, wcolor, rchar, rcolor;
  logic          is_read_ok;

  assign is_console = (item.opcode == tcse_pkg::OP_CONSOLE);
  assign cell_ok = (32'(item.cell_col) < SCREEN_COLS) && (32'(item.cell_row) < SCREEN_ROWS);

  // line numbers, each a sum below three ring lengths
  assign sum_cur  = XW'(head) + XW'(row);
  assign line_cur = (sum_cur >= XW'(RING_LINES)) ? sum_cur - XW'(RING_LINES) : sum_cur;
  assign sum_live  = XW'(head) + XW'(item.cell_row);
  assign line_live = (sum_live >= XW'(RING_LINES)) ? sum_live - XW'(RING_LINES) : sum_live;
  assign sum_vt = XW'(head) + XW'(RING_LINES) - XW'(view);
  assign line_view_t = (sum_vt >= XW'(RING_LINES)) ? sum_vt - XW'(RING_LINES) : sum_vt;
  assign sum_vu = line_view_t + XW'(item.cell_row);
  assign line_view = (sum_vu >= XW'(RING_LINES)) ? sum_vu - XW'(RING_LINES) : sum_vu;

  assign head_inc = (32'(head) == RING_LINES - 1) ? '0 : head + LW'(1);
  assign bottom_sum  = XW'(head_inc) + XW'(SCREEN_ROWS - 1);
  assign bottom_line = (bottom_sum >= XW'(RING_LINES)) ?
                       LW'(bottom_sum - XW'(RING_LINES)) : LW'(bottom_sum);

  assign prod      = AW'(32'(line_q) * SCREEN_COLS);
  assign addr_next = prod + (is_console ? AW'(col) : AW'(item.cell_col));
  assign vsum      = VW'(view) + VW'(item.line_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_color <= tcse_pkg::RESET_COLOR;
    end else if (cfg_wr_en) begin
      blank_color <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; phase <= '0; head <= '0; kept <= '0; view <= '0;
      scroll_q <= 1'b0;
      sweep_addr <= '0;
      sweep_end <= AW'(CELLS - 1);
    end else begin
      if (cmd.capture) begin
        item <= in_data;
      end
      if (cmd.line_en) begin
        case (cmd.line_sel)
          tcse_pkg::LINE_LIVE: line_q <= LW'(line_live);
          tcse_pkg::LINE_VIEW: line_q <= LW'(line_view);
          default:             line_q <= LW'(line_cur);
        endcase
      end
      if (cmd.addr_en) begin
        addr_q <= addr_next;
      end
      if (cmd.tab_load) begin
        tab_left <= TW'(TAB_STOP - 32'(phase));
      end
      if (cmd.step || cmd.newline) begin
        if (cmd.step && is_console && item.char_code == tcse_pkg::CH_TAB) begin
          tab_left <= tab_left - TW'(1);
        end
        if (cmd.step && 32'(col) != SCREEN_COLS - 1) begin
          col   <= col + CW'(1);
          phase <= (32'(phase) == TAB_STOP - 1) ? '0 : phase + PW'(1);
        end else begin
          col   <= '0;
          phase <= '0;
          if (32'(row) == SCREEN_ROWS - 1) begin
            head     <= head_inc;
            kept     <= (32'(kept) < KEPT_MAX) ? kept + LW'(1) : kept;
            line_q   <= bottom_line;
            scroll_q <= 1'b1;
          end else begin
            row <= row + RW'(1);
          end
        end
      end
      if (cmd.cret) begin
        col   <= '0;
        phase <= '0;
      end
      if (cmd.view_upd) begin
        case (item.opcode)
          tcse_pkg::OP_VUP: begin
            if (kept != '0) begin
              view <= (vsum > VW'(kept)) ? kept : LW'(vsum);
            end
          end
          tcse_pkg::OP_VDOWN: begin
            view <= (VW'(item.line_count) >= VW'(view)) ? '0 : view - LW'(item.line_count);
          end
          default: view <= '0;
        endcase
      end
      if (cmd.clear_regs) begin
        col <= '0; row <= '0; phase <= '0; head <= '0; kept <= '0; view <= '0;
      end
      if (cmd.sweep_line) begin
        sweep_addr <= prod;
        sweep_end  <= prod + AW'(SCREEN_COLS - 1);
        scroll_q   <= 1'b0;
      end
      if (cmd.sweep_screen) begin
        sweep_addr <= '0;
        sweep_end  <= AW'(SCREEN_ROWS * SCREEN_COLS - 1);
      end
      if (cmd.sweep_wr) begin
        sweep_addr <= sweep_addr + AW'(1);
      end
    end
  end

  // sweeps write blanks; otherwise a single cell at the formed address
  assign wr_k   = cmd.sweep_wr || cmd.wr_char;
  assign wr_c   = cmd.sweep_wr || cmd.wr_color;
  assign waddr  = cmd.sweep_wr ? sweep_addr : addr_q;
  assign wchar  = cmd.sweep_wr ? 8'h00 :
                  (is_console && item.char_code == tcse_pkg::CH_TAB) ? tcse_pkg::CH_SPACE :
                  item.char_code;
  assign wcolor = cmd.sweep_wr ? (cmd.sweep_init ? tcse_pkg::RESET_COLOR : blank_color) :
                  item.cell_color;

  tcse_ram #(.WIDTH(8), .DEPTH(CELLS)) u_char_ram (
    .clk(clk), .we(wr_k), .waddr(waddr), .wdata(wchar),
    .re(cmd.rd), .raddr(addr_q), .rdata(rchar)
  );

  tcse_ram #(.WIDTH(8), .DEPTH(CELLS)) u_color_ram (
    .clk(clk), .we(wr_c), .waddr(waddr), .wdata(wcolor),
    .re(cmd.rd), .raddr(addr_q), .rdata(rcolor)
  );

  assign is_read_ok = (item.opcode == tcse_pkg::OP_READ) && cell_ok;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.shown_char   <= is_read_ok ? rchar : 8'h00;
      out_data.shown_color  <= is_read_ok ? rcolor : 8'h00;
      out_data.cursor_col   <= 7'(col);
      out_data.cursor_row   <= 5'(row);
      out_data.cursor_pos   <= 11'(32'(row) * SCREEN_COLS + 32'(col));
      out_data.cursor_shown <= (view == '0);
      out_data.view_depth   <= 8'(view);
    end
  end

  assign st.opcode     = item.opcode;
  assign st.is_nl      = (item.char_code == tcse_pkg::CH_NL);
  assign st.is_cr      = (item.char_code == tcse_pkg::CH_CR);
  assign st.is_tab     = (item.char_code == tcse_pkg::CH_TAB);
  assign st.cell_ok    = cell_ok;
  assign st.scroll     = scroll_q;
  assign st.sweep_last = (sweep_addr == sweep_end);
  assign st.tab_more   = (tab_left != '0);

`ifndef ASSERT_OFF
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (rst)
    (32'(col) < SCREEN_COLS) && (32'(row) < SCREEN_ROWS))
    else $error("cursor outside screen");
  a_view_within_kept: assert property (@(posedge clk) disable iff (rst)
    view <= kept)
    else $error("view deeper than kept lines");
  a_kept_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (kept == $past(kept)) || (32'(kept) == 32'($past(kept)) + 1) || (kept == '0))
    else $error("kept lines jumped");
`endif

endmodule

// ===== src/tcse_ctrl.sv =====
// Controller state machine: input/output handshake and sequencing of datapath commands.
// Depends on tcse_pkg.
`timescale 1ns / 1ps

module tcse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  tcse_pkg::stat_t st,
  output tcse_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DECODE = 4'd2;
  localparam logic [3:0] S_LINE   = 4'd3;
  localparam logic [3:0] S_ADDR   = 4'd4;
  localparam logic [3:0] S_MEM    = 4'd5;
  localparam logic [3:0] S_CHK    = 4'd6;
  localparam logic [3:0] S_SWEEP  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;

  logic [3:0] state, state_next;
  logic       tab_cont;

  assign in_stall = (state != S_IDLE);
  assign tab_cont = (st.opcode == tcse_pkg::OP_CONSOLE) && st.is_tab && st.tab_more;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.sweep_wr   = 1'b1;
        cmd.sweep_init = 1'b1;
        if (st.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FIN;
        case (st.opcode)
          tcse_pkg::OP_CONSOLE: begin
            cmd.view_upd = 1'b1;
            if (st.is_nl) begin
              cmd.newline = 1'b1;
              state_next  = S_CHK;
            end else if (st.is_cr) begin
              cmd.cret = 1'b1;
            end else begin
              cmd.tab_load = st.is_tab;
              state_next   = S_LINE;
            end
          end
          tcse_pkg::OP_WCHAR, tcse_pkg::OP_WCOLOR, tcse_pkg::OP_READ: begin
            if (st.cell_ok) begin
              cmd.line_en  = 1'b1;
              cmd.line_sel = (st.opcode == tcse_pkg::OP_READ) ?
                             tcse_pkg::LINE_VIEW : tcse_pkg::LINE_LIVE;
              state_next   = S_ADDR;
            end
          end
          tcse_pkg::OP_VUP, tcse_pkg::OP_VDOWN: begin
            cmd.view_upd = 1'b1;
          end
          tcse_pkg::OP_CLEAR: begin
            cmd.clear_regs   = 1'b1;
            cmd.sweep_screen = 1'b1;
            state_next       = S_SWEEP;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_LINE: begin
        cmd.line_en  = 1'b1;
        cmd.line_sel = tcse_pkg::LINE_CURSOR;
        state_next   = S_ADDR;
      end
      S_ADDR: begin
        cmd.addr_en = 1'b1;
        state_next  = S_MEM;
      end
      S_MEM: begin
        state_next = S_FIN;
        case (st.opcode)
          tcse_pkg::OP_CONSOLE: begin
            cmd.wr_char = 1'b1;
            cmd.step    = 1'b1;
            state_next  = S_CHK;
          end
          tcse_pkg::OP_WCHAR:  cmd.wr_char  = 1'b1;
          tcse_pkg::OP_WCOLOR: cmd.wr_color = 1'b1;
          tcse_pkg::OP_READ:   cmd.rd       = 1'b1;
          default:             state_next   = S_FIN;
        endcase
      end
      S_CHK: begin
        if (st.scroll) begin
          cmd.sweep_line = 1'b1;
          state_next     = S_SWEEP;
        end else if (tab_cont) begin
          state_next = S_LINE;
        end else begin
          state_next = S_FIN;
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (st.sweep_last) begin
          state_next = tab_cont ? S_LINE : S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_take_in_sweep: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_wr |-> !cmd.capture && !cmd.load_out)
    else $error("sweep overlaps item transfer");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("result lost after load");
  a_state_legal: assert property (@(posedge clk) disable iff (rst)
    state <= S_FIN)
    else $error("illegal controller state");
`endif

endmodule

// ===== src/text_console_scrollback_engine_core.sv =====
// Top level of the text console scrollback engine: controller plus datapath.
// Depends on tcse_pkg, tcse_ctrl, tcse_datapath (and tcse_ram below it).
`timescale 1ns / 1ps

// Channel   Signals                      Transfer when
// input     in_valid, in_stall, in_data   in_valid & !in_stall
// output    out_valid, out_stall, out_data out_valid & !out_stall
// config    cfg_wr_en, cfg_wr_data        cfg_wr_en
//
// One item at a time. Decode, line and address forming and the cell access set
// the pace; a printable character also steps the cursor, and a tab writes one
// pad cell per step up to the next tab stop. A scroll blanks the SCREEN_COLS
// cells of the new line and clear blanks the whole screen, all through one RAM port.
// After reset a pass over all RING_LINES*SCREEN_COLS cells blanks the stores; no
// item is taken during it. A stalled result holds in the output register while
// the next item is already taken and worked on.

module text_console_scrollback_engine_core #(
  parameter int SCREEN_COLS = tcse_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcse_pkg::SCREEN_ROWS_DEF,
  parameter int RING_LINES  = tcse_pkg::RING_LINES_DEF,
  parameter int TAB_STOP    = tcse_pkg::TAB_STOP_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  tcse_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output tcse_pkg::out_t out_data,
  input  logic           cfg_wr_en,
  input  logic [7:0]     cfg_wr_data
);

  // command and status bundles between the sequencer and the datapath
  tcse_pkg::cmd_t  cmd;
  tcse_pkg::stat_t st;

  tcse_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall),
    .st(st), .cmd(cmd)
  );

  tcse_datapath #(
    .SCREEN_COLS(SCREEN_COLS), .SCREEN_ROWS(SCREEN_ROWS),
    .RING_LINES(RING_LINES), .TAB_STOP(TAB_STOP)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_data(in_data), .cmd(cmd), .st(st), .out_data(out_data)
  );

endmodule
